>>> hdl/op_timing_scheduler_core_assert.svh
// Assertion macros shared by the scheduler modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef OP_TIMING_SCHEDULER_CORE_ASSERT_SVH
`define OP_TIMING_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication.
`define OTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ots_pkg.sv
`timescale 1ns / 1ps

package ots_pkg;

    localparam int TIME_W = 48;

    typedef logic [TIME_W-1:0] time_t;

    typedef struct packed {
        logic [31:0] read_bytes;
        logic [31:0] write_bytes;
        logic [31:0] work_cycles;
        logic [7:0]  launch_overhead;
    } req_t;

    typedef struct packed {
        logic [1:0]  unit_chosen;
        time_t       start_time;
        time_t       end_time;
        logic [26:0] bus_read_cycles;
        logic [32:0] busy_cycles;
        logic [26:0] bus_write_cycles;
        time_t       op_number;
        time_t       makespan;
    } rsp_t;

    // Saturating time add; a is never above all-ones, b stays well below 2^47.
    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic time_t later(input time_t a, input time_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hdl/ots_cost.sv
`timescale 1ns / 1ps

`include "op_timing_scheduler_core_assert.svh"

module ots_cost #(
    parameter int BUS_BYTES_PER_CYCLE = 64,
    parameter int CYC_W = 27
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_ready,
    input  ots_pkg::req_t      src,
    output logic               dst_valid,
    input  logic               dst_ready,
    output logic [CYC_W-1:0]   rd_cycles,
    output logic [CYC_W-1:0]   wr_cycles,
    output logic [32:0]        busy_cycles
);

    // floor(y / C) == (y * RECIP) >> SHIFT for every 32-bit y
    localparam int SHIFT = 32 + $clog2(BUS_BYTES_PER_CYCLE);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + BUS_BYTES_PER_CYCLE - 1) / BUS_BYTES_PER_CYCLE;

    logic              valid_reg;
    logic [CYC_W-1:0]  rd_reg;
    logic [CYC_W-1:0]  wr_reg;
    logic [32:0]       busy_reg;

    logic [CYC_W-1:0]  rd_next;
    logic [CYC_W-1:0]  wr_next;
    logic [32:0]       busy_next;
    logic [64:0]       rd_prod;
    logic [64:0]       wr_prod;
    logic [64:0]       rd_quot;
    logic [64:0]       wr_quot;
    logic              load;

    assign src_ready = !valid_reg || dst_ready;
    assign load      = src_valid && src_ready;

    // Ceiling division as floor((bytes - 1) / C) + 1; zero bytes give zero cycles.
    always_comb
    begin
        rd_prod   = {33'b0, src.read_bytes - 32'd1} * {32'b0, 33'(RECIP)};
        wr_prod   = {33'b0, src.write_bytes - 32'd1} * {32'b0, 33'(RECIP)};
        rd_quot   = (rd_prod >> SHIFT) + 65'd1;
        wr_quot   = (wr_prod >> SHIFT) + 65'd1;
        rd_next   = (src.read_bytes == 32'd0) ? '0 : CYC_W'(rd_quot);
        wr_next   = (src.write_bytes == 32'd0) ? '0 : CYC_W'(wr_quot);
        busy_next = {1'b0, src.work_cycles} + {25'b0, src.launch_overhead};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src_ready)
        begin
            valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_reg   <= rd_next;
            wr_reg   <= wr_next;
            busy_reg <= busy_next;
        end
    end

    assign dst_valid   = valid_reg;
    assign rd_cycles   = rd_reg;
    assign wr_cycles   = wr_reg;
    assign busy_cycles = busy_reg;

    `OTS_ASSERT_NEXT(a_rd_zero, load, (rd_reg == '0) == ($past(src.read_bytes) == 32'd0), "read cycle count disagrees with zero byte count")

endmodule

>>> hdl/ots_sched.sv
`timescale 1ns / 1ps

`include "op_timing_scheduler_core_assert.svh"

module ots_sched #(
    parameter int NUM_UNITS = 4,
    parameter int CYC_W = 27
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cost_valid,
    output logic               cost_ready,
    input  logic [CYC_W-1:0]   rd_cycles,
    input  logic [CYC_W-1:0]   wr_cycles,
    input  logic [32:0]        busy_cycles,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ots_pkg::rsp_t      rsp
);

    localparam int IDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int LEAVES = 1 << IDX_W;
    localparam int NODES = 2 * LEAVES - 1;

    ots_pkg::time_t    bus_reg;
    ots_pkg::time_t    unit_reg [NUM_UNITS];
    ots_pkg::time_t    latest_reg;
    ots_pkg::time_t    ops_reg;
    logic              rsp_valid_reg;
    ots_pkg::rsp_t     rsp_reg;

    ots_pkg::time_t    bus_next;
    ots_pkg::time_t    latest_next;
    ots_pkg::time_t    ops_next;
    ots_pkg::rsp_t     rsp_next;

    ots_pkg::time_t    rd_finish;
    ots_pkg::time_t    work_finish;
    ots_pkg::time_t    wr_finish;
    ots_pkg::time_t    node_val [NODES];
    logic [IDX_W-1:0]  node_idx [NODES];
    logic [IDX_W-1:0]  best_idx;
    logic [IDX_W+1:0]  idx_ext;
    logic [CYC_W+26:0] rd_ext;
    logic [CYC_W+26:0] wr_ext;
    logic              load;

    assign cost_ready = !rsp_valid_reg || rsp_ready;
    assign load       = cost_valid && cost_ready;

    always_comb
    begin
        rd_finish = ots_pkg::sat_add(bus_reg, ots_pkg::TIME_W'(rd_cycles));

        // Leaves: earliest start on each unit; padding never wins a tie.
        for (int i = 0; i < NUM_UNITS; i++)
        begin
            node_val[LEAVES-1+i] = ots_pkg::later(rd_finish, unit_reg[i]);
            node_idx[LEAVES-1+i] = IDX_W'(i);
        end
        for (int i = NUM_UNITS; i < LEAVES; i++)
        begin
            node_val[LEAVES-1+i] = '1;
            node_idx[LEAVES-1+i] = IDX_W'(i);
        end
        // Minimum tree, left child wins ties so the lowest index is kept.
        for (int k = LEAVES - 2; k >= 0; k--)
        begin
            if (node_val[2*k+2] < node_val[2*k+1])
            begin
                node_val[k] = node_val[2*k+2];
                node_idx[k] = node_idx[2*k+2];
            end
            else
            begin
                node_val[k] = node_val[2*k+1];
                node_idx[k] = node_idx[2*k+1];
            end
        end
        best_idx = node_idx[0];

        work_finish = ots_pkg::sat_add(node_val[0], ots_pkg::TIME_W'(busy_cycles));
        wr_finish   = ots_pkg::sat_add(work_finish, ots_pkg::TIME_W'(wr_cycles));

        bus_next    = load ? wr_finish : bus_reg;
        latest_next = load ? ots_pkg::later(latest_reg, wr_finish) : latest_reg;
        ops_next    = (load && (ops_reg != '1)) ? ops_reg + 48'd1 : ops_reg;

        idx_ext = {2'b0, best_idx};
        rd_ext  = {27'b0, rd_cycles};
        wr_ext  = {27'b0, wr_cycles};

        rsp_next.unit_chosen      = idx_ext[1:0];
        rsp_next.start_time       = bus_reg;
        rsp_next.end_time         = wr_finish;
        rsp_next.bus_read_cycles  = rd_ext[26:0];
        rsp_next.busy_cycles      = busy_cycles;
        rsp_next.bus_write_cycles = wr_ext[26:0];
        rsp_next.op_number        = ops_next;
        rsp_next.makespan         = latest_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg       <= '0;
            latest_reg    <= '0;
            ops_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_UNITS; i++)
            begin
                unit_reg[i] <= '0;
            end
        end
        else
        begin
            bus_reg    <= bus_next;
            latest_reg <= latest_next;
            ops_reg    <= ops_next;
            if (cost_ready)
            begin
                rsp_valid_reg <= cost_valid;
            end
            for (int i = 0; i < NUM_UNITS; i++)
            begin
                if (load && (best_idx == IDX_W'(i)))
                begin
                    unit_reg[i] <= work_finish;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `OTS_ASSERT_NOW(a_phase_order, rsp_valid_reg, rsp_reg.start_time <= rsp_reg.end_time, "write completes before read starts")
    `OTS_ASSERT_NOW(a_span_cover, rsp_valid_reg, rsp_reg.makespan >= rsp_reg.end_time, "makespan below end time")
    `OTS_ASSERT_NEXT(a_op_count, load && (ops_reg != '1), ops_reg == $past(ops_reg) + 48'd1, "operation count did not advance")
    `OTS_ASSERT_NEXT(a_bus_mono, 1'b1, bus_reg >= $past(bus_reg), "bus ready time moved backwards")

endmodule

>>> hdl/op_timing_scheduler_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake              | Payload            | Moves
// ---------+------------------------+--------------------+-------------------------------
// request  | req_valid / req_ready  | req_data (req_t)   | one operation to place
// response | rsp_valid / rsp_ready  | rsp_data (rsp_t)   | placement and timing, one each
//
// One request per cycle sustained while rsp_ready stays high.
// Each request passes three registers: request capture, bus-cost stage (reciprocal multiply),
// and the schedule stage, where the state loop closes through its own registers.
// Stall: every stage loads when empty or when the stage after it drains; ready runs back
// combinationally from rsp_ready, so a held response still lets earlier stages fill.
// Reset (rst_n, asynchronous) empties the pipe and clears bus, unit, makespan and count state.
module op_timing_scheduler_core #(
    parameter int NUM_UNITS = 4,
    parameter int BUS_BYTES_PER_CYCLE = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ots_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ots_pkg::rsp_t rsp_data
);

    // Widest bus cycle count: ceiling of the largest byte count over the bus width.
    localparam longint unsigned MaxCycles =
        (64'hFFFF_FFFF + BUS_BYTES_PER_CYCLE - 1) / BUS_BYTES_PER_CYCLE;
    localparam int CYC_W = $clog2(MaxCycles + 1);

    logic               hold_valid_reg;
    ots_pkg::req_t      req_reg;
    logic               cost_in_ready;

    logic               cost_valid;
    logic               cost_ready;
    logic [CYC_W-1:0]   rd_cycles;
    logic [CYC_W-1:0]   wr_cycles;
    logic [32:0]        busy_cycles;

    // Capture the request; take a new one whenever this slot is empty or drains.
    assign req_ready = !hold_valid_reg || cost_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            hold_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req_data;
        end
    end

    // Bus read and write cycle counts and compute busy time.
    ots_cost #(
        .BUS_BYTES_PER_CYCLE (BUS_BYTES_PER_CYCLE),
        .CYC_W               (CYC_W)
    ) u_cost (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (hold_valid_reg),
        .src_ready   (cost_in_ready),
        .src         (req_reg),
        .dst_valid   (cost_valid),
        .dst_ready   (cost_ready),
        .rd_cycles   (rd_cycles),
        .wr_cycles   (wr_cycles),
        .busy_cycles (busy_cycles)
    );

    // Queue the read on the bus, pick the earliest unit, queue the write-back.
    ots_sched #(
        .NUM_UNITS (NUM_UNITS),
        .CYC_W     (CYC_W)
    ) u_sched (
        .clk         (clk),
        .rst_n       (rst_n),
        .cost_valid  (cost_valid),
        .cost_ready  (cost_ready),
        .rd_cycles   (rd_cycles),
        .wr_cycles   (wr_cycles),
        .busy_cycles (busy_cycles),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp_data)
    );

endmodule

>>> bench/tb_op_timing_scheduler_core.sv
`timescale 1ns / 1ps

module tb_op_timing_scheduler_core;

    localparam int UNITS      = 4;
    localparam int BUS_BYTES  = 64;
    localparam int LONG_HOLD  = 300;     // receiver hold-off in cycles, counted by the receiver
    localparam int PRESS_OPS  = 80;      // requests offered from the start of the receiver hold-off
    localparam longint LIMIT_NS = 10_000_000;

    localparam ots_pkg::time_t TIME_ALL_ONES = '1;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    ots_pkg::req_t  req_data;
    logic           rsp_valid;
    logic           rsp_ready;
    ots_pkg::rsp_t  rsp_data;

    op_timing_scheduler_core #(
        .NUM_UNITS           (UNITS),
        .BUS_BYTES_PER_CYCLE (BUS_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // Shadow of the schedule state, advanced once per accepted request.
    ots_pkg::time_t bus_ready_at;
    ots_pkg::time_t unit_ready_at [UNITS];
    ots_pkg::time_t span_so_far;
    ots_pkg::time_t ops_placed;

    // Placements still owed by the block, oldest first.
    ots_pkg::rsp_t  placement_q [$];

    // Idling switches and the long hold-off hand-over between sender and receiver.
    bit    send_idle;
    bit    recv_idle;
    bit    hold_request;

    int    mismatch_count;
    int    placements_checked;
    int    holds_done;

    // Directed stimulus: a known placement where it can be worked out by hand.
    typedef struct {
        ots_pkg::req_t op;
        bit            known;
        ots_pkg::rsp_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    always #5 clk = ~clk;

    // Hold reset at start-up, then release it for good.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bus cycles for a byte count: ceiling division, zero bytes cost nothing.
    function automatic ots_pkg::time_t bus_cost(input logic [31:0] bytes);
        logic [63:0] wide;
        wide = {32'd0, bytes};
        if (wide == 64'd0)
            return '0;
        return ots_pkg::time_t'((wide - 64'd1) / BUS_BYTES + 64'd1);
    endfunction

    // Time plus a cycle count, pinned at all-ones once it would run past.
    function automatic ots_pkg::time_t clamp_add(input ots_pkg::time_t t,
                                                 input ots_pkg::time_t d);
        if (d > TIME_ALL_ONES - t)
            return TIME_ALL_ONES;
        return t + d;
    endfunction

    // Place one operation: read on the bus, earliest free unit, then write-back on the bus.
    function automatic ots_pkg::rsp_t place_op(input ots_pkg::req_t op);
        ots_pkg::rsp_t  p;
        ots_pkg::time_t rd;
        ots_pkg::time_t wr;
        ots_pkg::time_t busy;
        ots_pkg::time_t rd_begin;
        ots_pkg::time_t rd_finish;
        ots_pkg::time_t pick_start;
        ots_pkg::time_t cand;
        ots_pkg::time_t work_finish;
        ots_pkg::time_t wr_finish;
        int             best;
        rd   = bus_cost(op.read_bytes);
        wr   = bus_cost(op.write_bytes);
        busy = ots_pkg::time_t'(op.launch_overhead) + ots_pkg::time_t'(op.work_cycles);

        rd_begin     = bus_ready_at;
        rd_finish    = clamp_add(rd_begin, rd);
        bus_ready_at = rd_finish;

        // Lowest index wins a tie: only a strictly earlier start displaces it.
        best       = 0;
        pick_start = (rd_finish > unit_ready_at[0]) ? rd_finish : unit_ready_at[0];
        for (int i = 1; i < UNITS; i++)
        begin
            cand = (rd_finish > unit_ready_at[i]) ? rd_finish : unit_ready_at[i];
            if (cand < pick_start)
            begin
                pick_start = cand;
                best       = i;
            end
        end

        work_finish         = clamp_add(pick_start, busy);
        unit_ready_at[best] = work_finish;

        wr_finish    = clamp_add((work_finish > bus_ready_at) ? work_finish : bus_ready_at, wr);
        bus_ready_at = wr_finish;
        if (wr_finish > span_so_far)
            span_so_far = wr_finish;
        if (ops_placed != TIME_ALL_ONES)
            ops_placed = ops_placed + 1'b1;

        p.unit_chosen      = best[1:0];
        p.start_time       = rd_begin;
        p.end_time         = wr_finish;
        p.bus_read_cycles  = rd[26:0];
        p.busy_cycles      = busy[32:0];
        p.bus_write_cycles = wr[26:0];
        p.op_number        = ops_placed;
        p.makespan         = span_so_far;
        return p;
    endfunction

    // Random operation: mostly small costs so the bus and units interleave, with
    // full-range values, zero counts and bytes either side of a bus-width multiple.
    function automatic ots_pkg::req_t random_op();
        ots_pkg::req_t op;
        int unsigned   pick;
        logic [31:0]   base;
        pick               = $urandom_range(0, 9);
        op.launch_overhead = 8'($urandom_range(0, 255));
        case (pick)
            0:
            begin
                op.read_bytes  = $urandom();
                op.write_bytes = $urandom();
                op.work_cycles = $urandom();
            end
            1:
            begin
                op.read_bytes  = $urandom_range(0, 1) ? 32'd0 : $urandom();
                op.write_bytes = $urandom_range(0, 1) ? 32'd0 : $urandom();
                op.work_cycles = $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 100);
                if ($urandom_range(0, 1))
                    op.launch_overhead = 8'd0;
            end
            2, 3:
            begin
                base = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4096);
                op.read_bytes  = (base & 32'hFFFF_FFC0) + 32'($urandom_range(0, 2)) - 32'd1;
                base = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 4096);
                op.write_bytes = (base & 32'hFFFF_FFC0) + 32'($urandom_range(0, 2)) - 32'd1;
                op.work_cycles = $urandom_range(0, 200);
            end
            default:
            begin
                op.read_bytes  = $urandom_range(0, 512);
                op.write_bytes = $urandom_range(0, 512);
                op.work_cycles = $urandom_range(0, 64);
            end
        endcase
        return op;
    endfunction

    function automatic void add_row(input ots_pkg::req_t op, input bit known,
                                    input ots_pkg::rsp_t want);
        dir_row_t r;
        r.op    = op;
        r.known = known;
        r.want  = want;
        dir_rows.push_back(r);
    endfunction

    // Offer one request, optionally after a gap, and log its placement once it is taken.
    // Valid is left high on acceptance: the next call either replaces the payload in
    // the same step or drops valid for a gap.
    task automatic send_op(input ots_pkg::req_t op, input bit known = 1'b0,
                           input ots_pkg::rsp_t want = '0);
        ots_pkg::rsp_t predicted;
        if (send_idle && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= op;
        do @(posedge clk); while (!req_ready);
        predicted = place_op(op);
        placement_q.push_back(known ? want : predicted);
    endtask

    // Drop valid and hold the sender back until every owed placement has come out.
    task automatic drain_placements();
        req_valid <= 1'b0;
        do @(posedge clk); while (placement_q.size() != 0);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: bursts of readiness and stalls, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Check every placement that leaves the block against the oldest one owed.
    always @(posedge clk)
    begin
        ots_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (placement_q.size() == 0)
            begin
                $error("placement with none outstanding: unit %0d start %0d end %0d",
                       rsp_data.unit_chosen, rsp_data.start_time, rsp_data.end_time);
                mismatch_count++;
            end
            else
            begin
                want = placement_q.pop_front();
                compare_field("unit_chosen", 64'(want.unit_chosen),
                              64'(rsp_data.unit_chosen));
                compare_field("start_time", 64'(want.start_time),
                              64'(rsp_data.start_time));
                compare_field("end_time", 64'(want.end_time),
                              64'(rsp_data.end_time));
                compare_field("bus_read_cycles", 64'(want.bus_read_cycles),
                              64'(rsp_data.bus_read_cycles));
                compare_field("busy_cycles", 64'(want.busy_cycles),
                              64'(rsp_data.busy_cycles));
                compare_field("bus_write_cycles", 64'(want.bus_write_cycles),
                              64'(rsp_data.bus_write_cycles));
                compare_field("op_number", 64'(want.op_number),
                              64'(rsp_data.op_number));
                compare_field("makespan", 64'(want.makespan),
                              64'(rsp_data.makespan));
                placements_checked++;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(LIMIT_NS);
        $display("op_timing_scheduler_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        int rnd_n;
        int heavy_n;
        rnd_n   = 0;
        heavy_n = 0;

        req_valid = 1'b0;
        req_data  = '0;

        bus_ready_at = '0;
        span_so_far  = '0;
        ops_placed   = '0;
        for (int i = 0; i < UNITS; i++)
            unit_ready_at[i] = '0;
        send_idle          = 1'b1;
        recv_idle          = 1'b1;
        hold_request       = 1'b0;
        mismatch_count     = 0;
        placements_checked = 0;
        holds_done         = 0;

        // Hand-worked chain from the reset state: all zeros, a single byte,
        // bytes just past and short of a bus width, pure launch overhead, then
        // every field at its top value.
        add_row(ots_pkg::req_t'{32'd0, 32'd0, 32'd0, 8'd0}, 1'b1,
                ots_pkg::rsp_t'{2'd0, 48'd0, 48'd0, 27'd0, 33'd0, 27'd0, 48'd1, 48'd0});
        add_row(ots_pkg::req_t'{32'd1, 32'd64, 32'd0, 8'd0}, 1'b1,
                ots_pkg::rsp_t'{2'd0, 48'd0, 48'd2, 27'd1, 33'd0, 27'd1, 48'd2, 48'd2});
        add_row(ots_pkg::req_t'{32'd65, 32'd63, 32'd10, 8'd5}, 1'b1,
                ots_pkg::rsp_t'{2'd0, 48'd2, 48'd20, 27'd2, 33'd15, 27'd1, 48'd3, 48'd20});
        add_row(ots_pkg::req_t'{32'd0, 32'd0, 32'd0, 8'd255}, 1'b1,
                ots_pkg::rsp_t'{2'd0, 48'd20, 48'd275, 27'd0, 33'd255, 27'd0, 48'd4,
                                48'd275});
        add_row(ots_pkg::req_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255}, 1'b1,
                ots_pkg::rsp_t'{2'd0, 48'd275, 48'd4429185553, 27'd67108864,
                                33'd4294967550, 27'd67108864, 48'd5, 48'd4429185553});
        // Bus-width edges on both sides, top work and overhead, bit patterns, single bytes.
        add_row(ots_pkg::req_t'{32'd63, 32'd128, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd64, 32'd129, 32'd1, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd128, 32'd127, 32'd0, 8'd1}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd129, 32'd0, 32'd7, 8'd3}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'hFFFF_FFC0, 32'hFFFF_FFBF, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'hFFFF_FFBF, 32'hFFFF_FFC0, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'hFFFF_FFC1, 32'hFFFF_FFC1, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd0, 32'd0, 32'hFFFF_FFFF, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd0, 32'd0, 32'd1, 8'd255}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 8'hAA}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 8'h55}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd1, 32'd1, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd0, 32'd1, 32'd0, 8'd0}, 1'b0, '0);
        add_row(ots_pkg::req_t'{32'd1, 32'd0, 32'd0, 8'd0}, 1'b0, '0);

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].known, dir_rows[i].want);

        // Random traffic with idling on both sides.
        repeat (430)
        begin
            send_op(random_op());
            rnd_n++;
        end

        // Back-pressure: hold the receiver off and keep offering requests until the
        // pipe fills and input ready drops; then let everything drain.
        hold_request = 1'b1;
        send_idle    = 1'b0;
        repeat (PRESS_OPS)
        begin
            send_op(random_op());
            rnd_n++;
        end
        drain_placements();

        // A stretch with no idling at all, then idling again.
        recv_idle = 1'b0;
        repeat (430)
        begin
            send_op(random_op());
            rnd_n++;
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (430)
        begin
            send_op(random_op());
            rnd_n++;
        end

        // Last part, no idling: heavy operations back to back to push the
        // schedule far out, then a few ordinary ones behind them.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        repeat (120)
        begin
            send_op(ots_pkg::req_t'{$urandom(), $urandom(), $urandom() | 32'hF000_0000,
                                    8'($urandom_range(0, 255))});
            heavy_n++;
        end
        repeat (30)
        begin
            send_op(random_op());
            heavy_n++;
        end

        drain_placements();
        repeat (10) @(posedge clk);

        $display("Covered %0d directed, %0d random and %0d heavy-tail requests.",
                 dir_rows.size(), rnd_n, heavy_n);
        $display("Checked %0d placements across %0d long receiver hold-offs.",
                 placements_checked, holds_done);
        if (mismatch_count == 0)
            $display("op_timing_scheduler_core test passed");
        else
            $display("op_timing_scheduler_core test failed");
        $finish;
    end

endmodule
